### sv/tftp_read_client_assert.svh
// ---------------------------------------------------------------------------
// tftp_read_client_assert.svh
// Assertion macros for the TFTP read client. Each macro expects clk and
// arst_n in scope and disables itself while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef TFTP_READ_CLIENT_ASSERT_SVH
`define TFTP_READ_CLIENT_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define TRC_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define TRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/tftp_rc_pkg.sv
// ---------------------------------------------------------------------------
// tftp_rc_pkg
// Shared types and constants of the TFTP read client.
// ---------------------------------------------------------------------------
`default_nettype none

package tftp_rc_pkg;

	// Width of byte counts and buffer offsets
	localparam int LEN_W = 24;
	localparam int HEADER_BYTES = 4;

	// Defaults of the top level parameters
	localparam int SEGMENT_SIZE_DEF = 512;
	localparam int RETRY_LIMIT_DEF = 4;

	// Reset value of the buffer size register
	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = {LEN_W{1'b1}};

	// TFTP opcodes seen by the filter
	localparam logic [15:0] TFTP_DATA = 16'd3;
	localparam logic [15:0] TFTP_ERROR = 16'd5;

	// Event codes
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_PACKET = 2'd1,
		OP_TIMEOUT = 2'd2
	} op_t;

	// Transfer status codes
	typedef enum logic [1:0] {
		ST_RUN = 2'd0,
		ST_OK = 2'd1,
		ST_SERVER_ERR = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// One input event
	typedef struct packed {
		logic [1:0] operation;
		logic [15:0] source_port;
		logic [15:0] opcode;
		logic [15:0] block_or_code;
		logic [15:0] packet_length;
	} evt_t;

	// One result
	typedef struct packed {
		logic send_request;
		logic send_ack;
		logic [15:0] ack_block;
		logic [15:0] ack_port;
		logic store_data;
		logic [LEN_W-1:0] store_offset;
		logic [15:0] store_length;
		logic transfer_done;
		status_t status;
		logic [15:0] server_error_code;
		logic [LEN_W-1:0] received_length;
	} res_t;

	// Step control between the stage logic and the transfer core
	typedef struct packed {
		logic fire;
		logic has_res;
	} step_ctl_t;

endpackage

`default_nettype wire

### sv/tftp_evt_if.sv
// ---------------------------------------------------------------------------
// tftp_evt_if
// Event channel: start, packet header or timeout.
// ---------------------------------------------------------------------------
`default_nettype none

interface tftp_evt_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [15:0] source_port;
	logic [15:0] opcode;
	logic [15:0] block_or_code;
	logic [15:0] packet_length;

	modport source (
		output valid, operation, source_port, opcode, block_or_code, packet_length,
		input ready
	);
	modport sink (
		input valid, operation, source_port, opcode, block_or_code, packet_length,
		output ready
	);
endinterface

`default_nettype wire

### sv/tftp_res_if.sv
// ---------------------------------------------------------------------------
// tftp_res_if
// Result channel: request, ack, store command and transfer status.
// ---------------------------------------------------------------------------
`default_nettype none

interface tftp_res_if;
	import tftp_rc_pkg::*;

	logic valid;
	logic ready;
	logic send_request;
	logic send_ack;
	logic [15:0] ack_block;
	logic [15:0] ack_port;
	logic store_data;
	logic [LEN_W-1:0] store_offset;
	logic [15:0] store_length;
	logic transfer_done;
	logic [1:0] status;
	logic [15:0] server_error_code;
	logic [LEN_W-1:0] received_length;

	modport source (
		output valid, send_request, send_ack, ack_block, ack_port, store_data,
		output store_offset, store_length, transfer_done, status,
		output server_error_code, received_length,
		input ready
	);
	modport sink (
		input valid, send_request, send_ack, ack_block, ack_port, store_data,
		input store_offset, store_length, transfer_done, status,
		input server_error_code, received_length,
		output ready
	);
endinterface

`default_nettype wire

### sv/tftp_cfg_if.sv
// ---------------------------------------------------------------------------
// tftp_cfg_if
// Configuration write channel for the buffer size register.
// ---------------------------------------------------------------------------
`default_nettype none

interface tftp_cfg_if;
	import tftp_rc_pkg::*;

	logic valid;
	logic ready;
	logic [LEN_W-1:0] max_length;

	modport source (output valid, max_length, input ready);
	modport sink (input valid, max_length, output ready);
endinterface

`default_nettype wire

### sv/tftp_rc_core.sv
// ---------------------------------------------------------------------------
// tftp_rc_core
// Transfer state and the per-event update: port filter, block check,
// buffer bound check, retry countdown and end of transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module tftp_rc_core #(
	parameter int SEGMENT_SIZE = tftp_rc_pkg::SEGMENT_SIZE_DEF,
	parameter int RETRY_LIMIT = tftp_rc_pkg::RETRY_LIMIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire tftp_rc_pkg::evt_t evt,
	input wire logic [tftp_rc_pkg::LEN_W-1:0] max_length,
	output tftp_rc_pkg::res_t res,
	output logic has_res
);
	import tftp_rc_pkg::*;

	localparam int RETRY_W = $clog2(RETRY_LIMIT + 1);
	localparam logic [RETRY_W-1:0] RETRY_RST = RETRY_W'(RETRY_LIMIT);
	localparam logic [15:0] SEG = 16'(SEGMENT_SIZE);
	localparam logic [15:0] HDR = 16'(HEADER_BYTES);

	// Transfer state
	logic [15:0] next_block_q, next_block_n;
	logic [15:0] server_port_q, server_port_n;
	logic [15:0] old_port_q, old_port_n;
	logic [LEN_W-1:0] byte_count_q, byte_count_n;
	logic overflow_q, overflow_n;
	logic [RETRY_W-1:0] retries_q, retries_n;
	logic ended_q, ended_n;

	// Working values
	logic [15:0] last_block;
	logic [15:0] dlen;
	logic [15:0] sp;
	logic drop;
	logic err_len;
	logic [LEN_W:0] sum;

	assign last_block = next_block_q - 16'd1;
	assign dlen = evt.packet_length - HDR;
	assign sum = {1'b0, byte_count_q} + {{(LEN_W - 15){1'b0}}, dlen};

	// Compute next state and the result of one event
	always_comb begin
		next_block_n = next_block_q;
		server_port_n = server_port_q;
		old_port_n = old_port_q;
		byte_count_n = byte_count_q;
		overflow_n = overflow_q;
		retries_n = retries_q;
		ended_n = ended_q;
		res = '0;
		has_res = 1'b1;
		err_len = 1'b0;
		sp = server_port_q;
		drop = 1'b0;
		case (evt.operation)
			OP_START: begin
				next_block_n = 16'd1;
				server_port_n = '0;
				byte_count_n = '0;
				overflow_n = 1'b0;
				retries_n = RETRY_RST;
				ended_n = 1'b0;
				res.send_request = 1'b1;
			end
			OP_TIMEOUT: begin
				if (ended_q) begin
					has_res = 1'b0;
				end else if (last_block != 16'd0) begin
					res.send_ack = 1'b1;
					res.ack_block = last_block;
					res.ack_port = server_port_q;
				end else if (retries_q <= RETRY_W'(1)) begin
					res.send_request = 1'b1;
					retries_n = RETRY_RST;
					byte_count_n = '0;
					next_block_n = 16'd1;
					old_port_n = server_port_q;
					server_port_n = '0;
				end else begin
					retries_n = retries_q - RETRY_W'(1);
				end
			end
			OP_PACKET: begin
				if (ended_q) begin
					has_res = 1'b0;
				end else begin
					retries_n = RETRY_RST;
					// Latch the server port on the first packet not from a straggler
					if (server_port_q == 16'd0) begin
						if (evt.source_port == old_port_q) begin
							drop = 1'b1;
						end else begin
							sp = evt.source_port;
							server_port_n = evt.source_port;
						end
					end
					if (!drop && sp == evt.source_port && evt.packet_length >= HDR) begin
						if (evt.opcode == TFTP_ERROR) begin
							ended_n = 1'b1;
							old_port_n = sp;
							res.transfer_done = 1'b1;
							res.status = ST_SERVER_ERR;
							res.server_error_code = evt.block_or_code;
							err_len = 1'b1;
						end else if (evt.opcode == TFTP_DATA
								&& evt.block_or_code <= next_block_q) begin
							if (evt.block_or_code != next_block_q) begin
								// Repeated block: ack the last good one again
								res.send_ack = 1'b1;
								res.ack_block = last_block;
								res.ack_port = sp;
							end else begin
								if (!overflow_q) begin
									if (sum > {1'b0, max_length}) begin
										overflow_n = 1'b1;
									end else begin
										res.store_data = 1'b1;
										res.store_offset = byte_count_q;
										res.store_length = dlen;
										byte_count_n = sum[LEN_W-1:0];
									end
								end
								res.send_ack = 1'b1;
								res.ack_block = next_block_q;
								res.ack_port = sp;
								next_block_n = next_block_q + 16'd1;
								// Short block ends the file
								if (dlen < SEG) begin
									ended_n = 1'b1;
									old_port_n = sp;
									res.transfer_done = 1'b1;
									res.status = overflow_n ? ST_OVERFLOW : ST_OK;
								end
							end
						end
					end
				end
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
		res.received_length = err_len ? {{(LEN_W - 16){1'b0}}, dlen} : byte_count_n;
	end

	// Commit state on each retired event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_block_q <= 16'd1;
			server_port_q <= '0;
			old_port_q <= '0;
			byte_count_q <= '0;
			overflow_q <= 1'b0;
			retries_q <= RETRY_RST;
			ended_q <= 1'b0;
		end else if (fire) begin
			next_block_q <= next_block_n;
			server_port_q <= server_port_n;
			old_port_q <= old_port_n;
			byte_count_q <= byte_count_n;
			overflow_q <= overflow_n;
			retries_q <= retries_n;
			ended_q <= ended_n;
		end
	end

endmodule

`default_nettype wire

### sv/tftp_read_client.sv
// ---------------------------------------------------------------------------
// tftp_read_client
// Receive side of a TFTP read transfer: at most one result per start, packet
// or timeout event, holding acks, store commands and end-of-file status.
// ---------------------------------------------------------------------------
//
//   channel  dir  contents
//   -------  ---  -------------------------------------------------------
//   evt      in   operation, source_port, opcode, block_or_code, length
//   res      out  request/ack/store command, done, status, byte counts
//   cfg      in   max_length write, always ready
//
// An event beat is registered in the input stage and its result in the
// result register; the transfer state updates as the event leaves the input
// stage, one event per cycle unless a stalled result blocks it.
// Reset is asynchronous and clears all control state; the buffer size
// returns to its full range. A stalled result holds in the output register
// while the input stage still takes one more beat; events with no result
// retire even under a stall.
// ---------------------------------------------------------------------------
`default_nettype none

module tftp_read_client #(
	parameter int SEGMENT_SIZE = tftp_rc_pkg::SEGMENT_SIZE_DEF,
	parameter int RETRY_LIMIT = tftp_rc_pkg::RETRY_LIMIT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	tftp_evt_if.sink evt,
	tftp_res_if.source res,
	tftp_cfg_if.sink cfg
);
	import tftp_rc_pkg::*;

	`include "tftp_read_client_assert.svh"

	logic [LEN_W-1:0] max_length_q;
	logic v_s1;
	evt_t evt_s1;
	logic v_s2;
	res_t res_s2;
	res_t res_c;
	step_ctl_t ctl;

	// Take configuration writes at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg.valid) begin
			max_length_q <= cfg.max_length;
		end
	end

	// Retire the staged event when its result has room or it has none
	assign ctl.fire = v_s1 && (!ctl.has_res || !v_s2 || res.ready);
	assign evt.ready = !v_s1 || ctl.fire;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (evt.ready) begin
			v_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			evt_s1 <= '{operation: evt.operation, source_port: evt.source_port,
				opcode: evt.opcode, block_or_code: evt.block_or_code,
				packet_length: evt.packet_length};
		end
	end

	tftp_rc_core #(
		.SEGMENT_SIZE(SEGMENT_SIZE),
		.RETRY_LIMIT(RETRY_LIMIT)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(ctl.fire),
		.evt(evt_s1),
		.max_length(max_length_q),
		.res(res_c),
		.has_res(ctl.has_res)
	);

	// Result register: load on a retired event with a result, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ctl.fire && ctl.has_res) begin
			v_s2 <= 1'b1;
		end else if (res.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire && ctl.has_res) begin
			res_s2 <= res_c;
		end
	end

	// Drive the result channel
	assign res.valid = v_s2;
	assign res.send_request = res_s2.send_request;
	assign res.send_ack = res_s2.send_ack;
	assign res.ack_block = res_s2.ack_block;
	assign res.ack_port = res_s2.ack_port;
	assign res.store_data = res_s2.store_data;
	assign res.store_offset = res_s2.store_offset;
	assign res.store_length = res_s2.store_length;
	assign res.transfer_done = res_s2.transfer_done;
	assign res.status = res_s2.status;
	assign res.server_error_code = res_s2.server_error_code;
	assign res.received_length = res_s2.received_length;

	// Checks
	`TRC_ASSERT(a_req_ack_excl, !(v_s2 && res_s2.send_request && res_s2.send_ack), "request and ack together")
	`TRC_ASSERT(a_status_done, !v_s2 || res_s2.transfer_done || res_s2.status == ST_RUN, "status without done")
	`TRC_ASSERT(a_store_bound, !(v_s2 && res_s2.store_data) || ({1'b0, res_s2.store_offset} + {{(LEN_W - 15){1'b0}}, res_s2.store_length} <= {1'b0, max_length_q}), "store beyond buffer")
	`TRC_ASSERT_NEXT(a_hold_result, v_s2 && !res.ready, v_s2, "stalled result lost")

endmodule

`default_nettype wire

### tb/tftp_read_client_test.sv
// ---------------------------------------------------------------------------
// tftp_read_client_test
// Self-checking bench for the TFTP read client. A queue of start, packet
// and timeout events feeds a clocked driver; every accepted beat runs
// through a local model of the transfer state. A clocked monitor compares
// each result beat, field by field, with the oldest outstanding prediction.
// Phases sweep the buffer size register and the idle and stall patterns.
// ---------------------------------------------------------------------------
`default_nettype none

module tftp_read_client_test;
	import tftp_rc_pkg::*;

	localparam logic [1:0] OP_UNDEFINED = 2'd3;
	localparam logic [15:0] FULL_LEN = 16'(SEGMENT_SIZE_DEF + HEADER_BYTES);
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	tftp_evt_if evt();
	tftp_res_if res();
	tftp_cfg_if cfg();

	tftp_read_client dut (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt),
		.res(res),
		.cfg(cfg)
	);

	// Model of the transfer state
	logic [LEN_W-1:0] buf_limit = MAX_LENGTH_RST;
	logic [15:0] nxt_blk = 16'd1;
	logic [15:0] srv_port = 16'd0;
	logic [15:0] stale_port = 16'd0;
	logic [LEN_W-1:0] stored_bytes = '0;
	logic overflowed = 1'b0;
	logic [2:0] retries = 3'(RETRY_LIMIT_DEF);
	logic xfer_done = 1'b0;

	evt_t queued_events[$];
	res_t due_replies[$];
	evt_t offered;
	res_t reply;
	res_t want;

	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_left = 0;
	logic hold_kick = 1'b0;
	int quiet_cycles = 0;
	int n_bad = 0;
	int n_events = 0;
	int n_checked = 0;
	int n_queued = 0;
	int n_sizes = 0;
	int n_ok = 0;
	int n_srv_err = 0;
	int n_ovf = 0;
	logic [15:0] last_port = 16'd0;

	always #6 clk = ~clk;

	// Apply one event to the transfer model; return 1 when it yields a result
	function automatic bit client_step(input evt_t e, output res_t r);
		logic [15:0] dlen;
		r = '0;
		if (e.operation == OP_UNDEFINED)
			return 1'b0;
		if (e.operation == OP_START) begin
			nxt_blk = 16'd1;
			srv_port = 16'd0;
			stored_bytes = '0;
			overflowed = 1'b0;
			retries = 3'(RETRY_LIMIT_DEF);
			xfer_done = 1'b0;
			r.send_request = 1'b1;
			r.received_length = stored_bytes;
			return 1'b1;
		end
		if (xfer_done)
			return 1'b0;
		if (e.operation == OP_TIMEOUT) begin
			if (nxt_blk - 16'd1 != 16'd0) begin
				// re-ack the last good block
				r.send_ack = 1'b1;
				r.ack_block = nxt_blk - 16'd1;
				r.ack_port = srv_port;
			end else if (retries <= 3'd1) begin
				// give up on this server and ask again
				r.send_request = 1'b1;
				retries = 3'(RETRY_LIMIT_DEF);
				stored_bytes = '0;
				nxt_blk = 16'd1;
				stale_port = srv_port;
				srv_port = 16'd0;
			end else begin
				retries = retries - 3'd1;
			end
			r.received_length = stored_bytes;
			return 1'b1;
		end
		retries = 3'(RETRY_LIMIT_DEF);
		r.received_length = stored_bytes;
		// lock onto the first server that is not the straggler
		if (srv_port == 16'd0) begin
			if (e.source_port == stale_port)
				return 1'b1;
			srv_port = e.source_port;
		end
		if (srv_port != e.source_port || e.packet_length < 16'(HEADER_BYTES))
			return 1'b1;
		dlen = e.packet_length - 16'(HEADER_BYTES);
		if (e.opcode == TFTP_ERROR) begin
			xfer_done = 1'b1;
			stale_port = srv_port;
			r.transfer_done = 1'b1;
			r.status = ST_SERVER_ERR;
			r.server_error_code = e.block_or_code;
			r.received_length = LEN_W'(dlen);
			return 1'b1;
		end
		if (e.opcode != TFTP_DATA || e.block_or_code > nxt_blk)
			return 1'b1;
		if (e.block_or_code < nxt_blk) begin
			r.send_ack = 1'b1;
			r.ack_block = nxt_blk - 16'd1;
			r.ack_port = srv_port;
			return 1'b1;
		end
		// in-order block: store unless it would overflow the buffer
		if (!overflowed) begin
			if (32'(stored_bytes) + 32'(dlen) > 32'(buf_limit)) begin
				overflowed = 1'b1;
			end else begin
				r.store_data = 1'b1;
				r.store_offset = stored_bytes;
				r.store_length = dlen;
				stored_bytes = stored_bytes + LEN_W'(dlen);
			end
		end
		r.send_ack = 1'b1;
		r.ack_block = nxt_blk;
		r.ack_port = srv_port;
		nxt_blk = nxt_blk + 16'd1;
		if (dlen < 16'(SEGMENT_SIZE_DEF)) begin
			xfer_done = 1'b1;
			stale_port = srv_port;
			r.transfer_done = 1'b1;
			r.status = overflowed ? ST_OVERFLOW : ST_OK;
		end
		r.received_length = stored_bytes;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] exp_val);
		n_bad++;
		if (n_bad <= 40)
			$display("mismatch in result %0d, %s: got %0h, model %0h",
				n_checked, what, got, exp_val);
	endtask

	task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch(what, got, exp_val);
	endtask

	task automatic queue_evt(input logic [1:0] op, input logic [15:0] port,
			input logic [15:0] opc, input logic [15:0] blk, input logic [15:0] len);
		evt_t e;
		e.operation = op;
		e.source_port = port;
		e.opcode = opc;
		e.block_or_code = blk;
		e.packet_length = len;
		queued_events.push_back(e);
		n_queued++;
	endtask

	// One transfer with random content: blocks in order, with faults mixed in
	task automatic queue_transfer(input int n_blocks);
		logic [15:0] port;
		logic [15:0] blk;
		logic [15:0] len;
		int k;
		port = 16'($urandom_range(16'hFFFF, 1));
		queue_evt(OP_START, 16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
		if ($urandom_range(3) == 0) begin
			if ($urandom_range(1) == 0)
				queue_evt(OP_PACKET, last_port, TFTP_DATA, 16'd1, FULL_LEN);
			repeat ($urandom_range(6))
				queue_evt(OP_TIMEOUT, 16'($urandom()), 16'($urandom()),
					16'($urandom()), 16'($urandom()));
		end
		blk = 16'd1;
		for (k = 0; k < n_blocks; k++) begin
			case ($urandom_range(15))
				0: queue_evt(OP_PACKET, port, TFTP_DATA, blk - 16'($urandom_range(3, 1)),
					FULL_LEN);
				1: queue_evt(OP_PACKET, port ^ (16'd1 << $urandom_range(15)), TFTP_DATA, blk,
					FULL_LEN);
				2: queue_evt(OP_TIMEOUT, 16'($urandom()), 16'($urandom()), 16'($urandom()),
					16'($urandom()));
				3: queue_evt(OP_PACKET, port, TFTP_DATA, blk + 16'($urandom_range(4, 1)),
					FULL_LEN);
				4: queue_evt(OP_PACKET, port, 16'($urandom()), blk, FULL_LEN);
				5: queue_evt(OP_PACKET, port, TFTP_DATA, blk,
					16'($urandom_range(HEADER_BYTES - 1)));
				6: queue_evt(2'($urandom()), 16'($urandom()), 16'($urandom()),
					16'($urandom()), 16'($urandom()));
				default: ;
			endcase
			len = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFF, FULL_LEN + 1))
				: FULL_LEN;
			queue_evt(OP_PACKET, port, TFTP_DATA, blk, len);
			blk = blk + 16'd1;
		end
		// close with a short block, a server error, or leave it open
		case ($urandom_range(4))
			0, 1, 2: queue_evt(OP_PACKET, port, TFTP_DATA, blk,
				16'($urandom_range(FULL_LEN - 1, HEADER_BYTES)));
			3: queue_evt(OP_PACKET, port, TFTP_ERROR, 16'($urandom()), 16'($urandom()));
			default: ;
		endcase
		if ($urandom_range(3) == 0)
			queue_evt(2'($urandom()), port, TFTP_DATA, blk + 16'd1, FULL_LEN);
		last_port = port;
	endtask

	// Wait until every event is taken and every result has come back
	task automatic settle();
		do
			@(negedge clk);
		while (queued_events.size() != 0 || evt.valid || due_replies.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_max_length(input logic [LEN_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.max_length <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		buf_limit = v;
		n_sizes++;
	endtask

	// Event driver: score the beat taken at this edge, then offer the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			evt.valid <= 1'b0;
		end else begin
			if (evt.valid && evt.ready) begin
				n_events++;
				if (client_step(offered, reply))
					due_replies.push_back(reply);
			end
			if (!evt.valid || evt.ready) begin
				if (queued_events.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					offered = queued_events.pop_front();
					evt.valid <= 1'b1;
					evt.operation <= offered.operation;
					evt.source_port <= offered.source_port;
					evt.opcode <= offered.opcode;
					evt.block_or_code <= offered.block_or_code;
					evt.packet_length <= offered.packet_length;
				end else begin
					evt.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each beat with the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (due_replies.size() == 0) begin
					report_mismatch("result with none outstanding", 32'd1, 32'd0);
				end else begin
					want = due_replies.pop_front();
					check_field("send_request", 32'(res.send_request),
						32'(want.send_request));
					check_field("send_ack", 32'(res.send_ack), 32'(want.send_ack));
					check_field("ack_block", 32'(res.ack_block), 32'(want.ack_block));
					check_field("ack_port", 32'(res.ack_port), 32'(want.ack_port));
					check_field("store_data", 32'(res.store_data), 32'(want.store_data));
					check_field("store_offset", 32'(res.store_offset),
						32'(want.store_offset));
					check_field("store_length", 32'(res.store_length),
						32'(want.store_length));
					check_field("transfer_done", 32'(res.transfer_done),
						32'(want.transfer_done));
					check_field("status", 32'(res.status), 32'(want.status));
					check_field("server_error_code", 32'(res.server_error_code),
						32'(want.server_error_code));
					check_field("received_length", 32'(res.received_length),
						32'(want.received_length));
					n_checked++;
					if (want.status == ST_OK)
						n_ok++;
					if (want.status == ST_SERVER_ERR)
						n_srv_err++;
					if (want.status == ST_OVERFLOW)
						n_ovf++;
				end
			end
			res.ready <= hold_left == 0 && $urandom_range(99) >= rcv_stall_pct;
		end
	end

	// Long receiver hold-off, counted here
	always @(posedge clk) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_kick)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// Watchdog: end the run when no channel moves a beat for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((evt.valid && evt.ready) || (res.valid && res.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no beat moved for %0d cycles", quiet_cycles);
			$display("tftp_read_client_test: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		evt.valid = 1'b0;
		evt.operation = OP_START;
		evt.source_port = '0;
		evt.opcode = '0;
		evt.block_or_code = '0;
		evt.packet_length = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.max_length = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: filter cases, repeats, end of file, straggler, server error
		set_max_length(MAX_LENGTH_RST);
		queue_evt(OP_UNDEFINED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		repeat (4) queue_evt(OP_TIMEOUT, 16'h0, 16'h0, 16'h0, 16'h0);
		queue_evt(OP_START, 16'h0, 16'h0, 16'h0, 16'h0);
		queue_evt(OP_PACKET, 16'h1234, TFTP_DATA, 16'd1, 16'd3);
		queue_evt(OP_PACKET, 16'hFFFF, TFTP_DATA, 16'd1, FULL_LEN);
		queue_evt(OP_PACKET, 16'h1234, 16'hFFFF, 16'd1, FULL_LEN);
		queue_evt(OP_PACKET, 16'h1234, TFTP_DATA, 16'd2, FULL_LEN);
		queue_evt(OP_PACKET, 16'h1234, TFTP_DATA, 16'd1, FULL_LEN);
		queue_evt(OP_PACKET, 16'h1234, TFTP_DATA, 16'd1, FULL_LEN);
		queue_evt(OP_PACKET, 16'h1234, TFTP_DATA, 16'd0, 16'hFFFF);
		queue_evt(OP_TIMEOUT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_evt(OP_PACKET, 16'h1234, TFTP_DATA, 16'd2, 16'hFFFF);
		queue_evt(OP_PACKET, 16'h1234, TFTP_DATA, 16'd3, 16'(HEADER_BYTES));
		queue_evt(OP_PACKET, 16'h1234, TFTP_DATA, 16'd4, FULL_LEN);
		queue_evt(OP_TIMEOUT, 16'h0, 16'h0, 16'h0, 16'h0);
		queue_evt(OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_evt(OP_PACKET, 16'h1234, TFTP_DATA, 16'd1, FULL_LEN);
		queue_evt(OP_PACKET, 16'h0000, TFTP_ERROR, 16'hFFFF, 16'hFFFF);
		queue_evt(OP_START, 16'h0, 16'h0, 16'h0, 16'h0);
		queue_evt(OP_PACKET, 16'hABCD, TFTP_ERROR, 16'h0000, 16'(HEADER_BYTES));
		settle();

		// Empty buffer: overflow on the first block; receiver stalls
		set_max_length('0);
		rcv_stall_pct <= 70;
		queue_evt(OP_START, 16'h0, 16'h0, 16'h0, 16'h0);
		queue_evt(OP_PACKET, 16'h0F0F, TFTP_DATA, 16'd1, FULL_LEN);
		queue_evt(OP_PACKET, 16'h0F0F, TFTP_DATA, 16'd2, 16'd5);
		queue_evt(OP_START, 16'h0, 16'h0, 16'h0, 16'h0);
		queue_evt(OP_PACKET, 16'h0F0F, TFTP_DATA, 16'd1, 16'(HEADER_BYTES));
		n_queued = 0;
		while (n_queued < 250)
			queue_transfer($urandom_range(10));
		settle();

		// Mid-size buffer; sender idles
		set_max_length(LEN_W'($urandom_range(6000, 512)));
		rcv_stall_pct <= 0;
		snd_idle_pct <= 70;
		n_queued = 0;
		while (n_queued < 250)
			queue_transfer($urandom_range(12));
		settle();

		// Small buffer; both sides idle a little
		set_max_length(LEN_W'($urandom_range(2048, 1024)));
		rcv_stall_pct <= 11;
		snd_idle_pct <= 11;
		n_queued = 0;
		while (n_queued < 250)
			queue_transfer($urandom_range(12));
		settle();

		// Full buffer: hold the receiver off while the sender keeps offering
		set_max_length(MAX_LENGTH_RST);
		rcv_stall_pct <= 0;
		snd_idle_pct <= 0;
		hold_kick <= 1'b1;
		n_queued = 0;
		while (n_queued < 80)
			queue_transfer($urandom_range(8));
		@(posedge clk);
		hold_kick <= 1'b0;
		settle();

		// Random buffer size; mixed idling
		set_max_length(LEN_W'($urandom_range(24'hFFFFFF)));
		rcv_stall_pct <= 70;
		snd_idle_pct <= 70;
		n_queued = 0;
		while (n_queued < 250)
			queue_transfer($urandom_range(12));
		settle();
		repeat (12) @(posedge clk);

		$display("covered %0d events and %0d results under %0d buffer sizes",
			n_events, n_checked, n_sizes);
		$display("transfers ended: %0d complete, %0d server error, %0d overflow",
			n_ok, n_srv_err, n_ovf);
		if (n_bad == 0) begin
			$display("tftp_read_client_test: clean");
		end else begin
			$display("%0d mismatches", n_bad);
			$display("tftp_read_client_test: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
